// File: design/lbvs_pkg.sv
// shared constants, command and status types for the vertex skinning block
package lbvs_pkg;

  localparam int MAX_JOINTS      = 64;
  localparam int MAX_INFLUENCES  = 4;
  localparam int WORDS_PER_JOINT = 12;
  localparam int MEM_DEPTH       = MAX_JOINTS * WORDS_PER_JOINT;
  localparam int ADDR_W          = $clog2(MEM_DEPTH);
  localparam int CNT_W           = $clog2(MAX_INFLUENCES + 1);
  localparam int JC_W            = 7;

  localparam logic [15:0] ONE_WEIGHT = 16'd32768;
  localparam logic [15:0] NORM_ONE   = 16'd16384;
  localparam logic [3:0]  DIV_TOP    = 4'd14;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_READ,
    OP_MUL_POS,
    OP_ADD_TRANS,
    OP_MUL_NRM,
    OP_ADD_NRM,
    OP_WHI,
    OP_WLO,
    OP_WACC,
    OP_NORM_INIT,
    OP_NSHR,
    OP_NSHL,
    OP_SQ,
    OP_SQACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] row;
    logic [1:0] col;
    logic       sel;
    logic [1:0] comp;
    logic [3:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_write;
    logic skip;
    logic last;
    logic out_busy;
    logic top_zero;
    logic top_big;
    logic top_small;
    logic sqrt_last;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_MPOS,
    ST_MNRM,
    ST_ANRM,
    ST_WHI,
    ST_WLO,
    ST_WACC,
    ST_COUNT,
    ST_NINIT,
    ST_NSCALE,
    ST_SQ,
    ST_SQACC,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DINIT,
    ST_DSTEP,
    ST_DEND,
    ST_EMIT
  } ctrl_state_e;

endpackage

// File: design/lbvs_dp.sv
// skinning datapath: matrix memory, shared multiplier, accumulators, normalise unit
module lbvs_dp import lbvs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic                cfg_we_i,
  input  logic [JC_W-1:0]     cfg_wdata_i,
  input  logic                command_i,
  input  logic [5:0]          joint_i,
  input  logic [3:0]          word_index_i,
  input  logic signed [31:0]  word_value_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [15:0]  norm_x_i,
  input  logic signed [15:0]  norm_y_i,
  input  logic signed [15:0]  norm_z_i,
  input  logic [15:0]         weight_i,
  input  logic                last_influence_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  out_pos_x_o,
  output logic signed [31:0]  out_pos_y_o,
  output logic signed [31:0]  out_pos_z_o,
  output logic signed [15:0]  out_norm_x_o,
  output logic signed [15:0]  out_norm_y_o,
  output logic signed [15:0]  out_norm_z_o
);

  logic [JC_W-1:0]    joint_count_q;
  logic [31:0]        mem [MEM_DEPTH];
  logic [31:0]        rdata_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;

  logic signed [31:0] pos_q [3];
  logic signed [15:0] nrm_q [3];
  logic [15:0]        weight_q;
  logic [5:0]         joint_q;
  logic               last_q;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_q;
  logic signed [41:0] hi_q;
  logic signed [49:0] ps_q;
  logic signed [33:0] ns_q;
  logic signed [49:0] wv;
  logic signed [67:0] wfull;
  logic signed [52:0] wterm;
  logic signed [53:0] psum;
  logic signed [53:0] nsum;
  logic signed [47:0] psat;
  logic signed [39:0] nsat;

  logic signed [47:0] accp_q [3];
  logic signed [39:0] accn_q [3];

  logic [39:0]        mag_q [3];
  logic               neg_q [3];
  logic [39:0]        top_q;
  logic [39:0]        mag_d [3];
  logic [39:0]        top_d;
  logic [61:0]        len2_q;
  logic [63:0]        sv_q;
  logic [63:0]        res_q;
  logic [63:0]        bit_q;
  logic [63:0]        trial;
  logic [45:0]        num_q;
  logic [46:0]        dsh;
  logic [14:0]        quo_q;
  logic signed [15:0] nout_q [3];

  logic               out_valid_q;
  logic signed [31:0] opos_q [3];
  logic signed [15:0] onrm_q [3];
  logic signed [31:0] psat32 [3];

  // matrix word addresses
  assign mem_we = (cmd_i.op == OP_ACCEPT) && !command_i
                  && (word_index_i < 4'(WORDS_PER_JOINT)) && (int'(joint_i) < MAX_JOINTS);
  assign waddr  = ADDR_W'(int'(joint_i) * WORDS_PER_JOINT + int'(word_index_i));
  assign raddr  = ADDR_W'(int'(joint_q) * WORDS_PER_JOINT + int'(cmd_i.col) * 3
                          + int'(cmd_i.row));

  // skin matrix memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= word_value_i;
    end
    if (cmd_i.op == OP_READ) begin
      rdata_q <= mem[raddr];
    end
  end

  // joint count register and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        joint_count_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared multiplier operand selection
  assign wv = cmd_i.sel ? {{16{ns_q[33]}}, ns_q} : ps_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_POS: begin
        mul_a = {rdata_q[31], rdata_q};
        mul_b = {pos_q[cmd_i.col][31], pos_q[cmd_i.col]};
      end
      OP_MUL_NRM: begin
        mul_a = {rdata_q[31], rdata_q};
        mul_b = {{17{nrm_q[cmd_i.col][15]}}, nrm_q[cmd_i.col]};
      end
      OP_WHI: begin
        mul_a = {{8{wv[49]}}, wv[49:25]};
        mul_b = {17'b0, weight_q};
      end
      OP_WLO: begin
        mul_a = {8'b0, wv[24:0]};
        mul_b = {17'b0, weight_q};
      end
      OP_SQ: begin
        mul_a = {3'b0, mag_q[cmd_i.comp][29:0]};
        mul_b = {3'b0, mag_q[cmd_i.comp][29:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // weighted term, floor shift by 15, and saturating accumulate
  assign wfull = $signed({hi_q[41], hi_q, 25'b0}) + $signed({{2{prod_q[65]}}, prod_q});
  assign wterm = wfull[67:15];
  assign psum  = $signed({{6{accp_q[cmd_i.row][47]}}, accp_q[cmd_i.row]})
                 + $signed({wterm[52], wterm});
  assign nsum  = $signed({{14{accn_q[cmd_i.row][39]}}, accn_q[cmd_i.row]})
                 + $signed({wterm[52], wterm});
  assign psat  = (psum[53:47] == {7{psum[53]}}) ? psum[47:0]
               : (psum[53] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}});
  assign nsat  = (nsum[53:39] == {15{nsum[53]}}) ? nsum[39:0]
               : (nsum[53] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}});

  // magnitudes and largest component of the summed normal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = accn_q[i][39] ? (~accn_q[i] + 40'd1) : accn_q[i];
    end
    top_d = mag_d[0];
    if (mag_d[1] > top_d) begin
      top_d = mag_d[1];
    end
    if (mag_d[2] > top_d) begin
      top_d = mag_d[2];
    end
  end

  // square root trial and divisor shift
  assign trial = res_q + bit_q;
  assign dsh   = 47'(res_q[31:0]) << cmd_i.step;

  // positions saturated to 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psat32[i] = (accp_q[i][47:31] == {17{accp_q[i][47]}}) ? accp_q[i][31:0]
                : (accp_q[i][47] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});
    end
  end

  // accumulators, cleared by reset and after each result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        accp_q[i] <= '0;
        accn_q[i] <= '0;
      end
    end else begin
      if (cmd_i.op == OP_WACC) begin
        if (cmd_i.sel) begin
          accn_q[cmd_i.row] <= nsat;
        end else begin
          accp_q[cmd_i.row] <= psat;
        end
      end else if (cmd_i.op == OP_EMIT) begin
        for (int i = 0; i < 3; i++) begin
          accp_q[i] <= '0;
          accn_q[i] <= '0;
        end
      end
    end
  end

  // working registers of the datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_ACCEPT: begin
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
        nrm_q[0] <= norm_x_i;
        nrm_q[1] <= norm_y_i;
        nrm_q[2] <= norm_z_i;
        weight_q <= (weight_i > ONE_WEIGHT) ? ONE_WEIGHT : weight_i;
        joint_q  <= joint_i;
        last_q   <= last_influence_i;
      end
      OP_READ: begin
        if (cmd_i.col == 2'd0) begin
          ps_q <= '0;
          ns_q <= '0;
        end
      end
      OP_ADD_TRANS: ps_q <= ps_q + $signed({{18{rdata_q[31]}}, rdata_q});
      OP_MUL_NRM:   ps_q <= ps_q + $signed(prod_q[65:16]);
      OP_ADD_NRM:   ns_q <= ns_q + $signed(prod_q[49:16]);
      OP_WLO:       hi_q <= prod_q[41:0];
      OP_NORM_INIT: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= mag_d[i];
          neg_q[i] <= accn_q[i][39];
        end
        top_q  <= top_d;
        len2_q <= '0;
      end
      OP_NSHR: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= mag_q[i] >> 1;
        end
        top_q <= top_q >> 1;
      end
      OP_NSHL: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= mag_q[i] << 1;
        end
        top_q <= top_q << 1;
      end
      OP_SQACC: len2_q <= len2_q + prod_q[61:0];
      OP_SQRT_INIT: begin
        sv_q  <= {2'b0, len2_q};
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sv_q >= trial) begin
          sv_q  <= sv_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DIV_INIT: begin
        num_q <= 46'({mag_q[cmd_i.comp][29:0], 14'b0}) + 46'(res_q[31:1]);
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        if ({1'b0, num_q} >= dsh) begin
          num_q <= 46'({1'b0, num_q} - dsh);
          quo_q[cmd_i.step] <= 1'b1;
        end
      end
      OP_DIV_END: begin
        nout_q[cmd_i.comp] <= neg_q[cmd_i.comp] ? (~{1'b0, quo_q} + 16'd1) : {1'b0, quo_q};
      end
      OP_EMIT: begin
        for (int i = 0; i < 3; i++) begin
          opos_q[i] <= psat32[i];
        end
        if (top_q == '0) begin
          onrm_q[0] <= '0;
          onrm_q[1] <= NORM_ONE;
          onrm_q[2] <= '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            onrm_q[i] <= nout_q[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // status back to the controller
  always_comb begin
    status_o.is_write  = !command_i;
    status_o.skip      = (weight_i == '0) || ({1'b0, joint_i} >= joint_count_q)
                         || (int'(joint_i) >= MAX_JOINTS);
    status_o.last      = last_q;
    status_o.out_busy  = out_valid_q && !out_ready_i;
    status_o.top_zero  = (top_q == '0);
    status_o.top_big   = |top_q[39:30];
    status_o.top_small = (top_q[39:29] == '0);
    status_o.sqrt_last = bit_q[0];
  end

  assign out_valid_o  = out_valid_q;
  assign out_pos_x_o  = opos_q[0];
  assign out_pos_y_o  = opos_q[1];
  assign out_pos_z_o  = opos_q[2];
  assign out_norm_x_o = onrm_q[0];
  assign out_norm_y_o = onrm_q[1];
  assign out_norm_z_o = onrm_q[2];

endmodule

// File: design/lbvs_ctrl.sv
// skinning controller: sequences the datapath through each request
module lbvs_ctrl import lbvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [1:0]       row_q, row_d;
  logic [1:0]       col_q, col_d;
  logic             sel_q, sel_d;
  logic [1:0]       comp_q, comp_d;
  logic [3:0]       step_q, step_d;
  logic [CNT_W-1:0] count_q, count_d;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      sel_q   <= 1'b0;
      comp_q  <= '0;
      step_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      sel_q   <= sel_d;
      comp_q  <= comp_d;
      step_q  <= step_d;
      count_q <= count_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    sel_d      = sel_q;
    comp_d     = comp_q;
    step_d     = step_q;
    count_d    = count_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.row  = row_q;
    cmd_o.col  = col_q;
    cmd_o.sel  = sel_q;
    cmd_o.comp = comp_q;
    cmd_o.step = step_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (!status_i.is_write) begin
            row_d = '0;
            col_d = '0;
            sel_d = 1'b0;
            state_d = status_i.skip ? ST_COUNT : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.op = OP_READ;
        state_d  = ST_MPOS;
      end
      ST_MPOS: begin
        if (col_q == 2'd3) begin
          cmd_o.op = OP_ADD_TRANS;
          state_d  = ST_WHI;
        end else begin
          cmd_o.op = OP_MUL_POS;
          state_d  = ST_MNRM;
        end
      end
      ST_MNRM: begin
        cmd_o.op = OP_MUL_NRM;
        state_d  = ST_ANRM;
      end
      ST_ANRM: begin
        cmd_o.op = OP_ADD_NRM;
        col_d    = col_q + 2'd1;
        state_d  = ST_READ;
      end
      ST_WHI: begin
        cmd_o.op = OP_WHI;
        state_d  = ST_WLO;
      end
      ST_WLO: begin
        cmd_o.op = OP_WLO;
        state_d  = ST_WACC;
      end
      ST_WACC: begin
        cmd_o.op = OP_WACC;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_WHI;
        end else begin
          sel_d = 1'b0;
          col_d = '0;
          if (row_q == 2'd2) begin
            row_d   = '0;
            state_d = ST_COUNT;
          end else begin
            row_d   = row_q + 2'd1;
            state_d = ST_READ;
          end
        end
      end
      ST_COUNT: begin
        if (status_i.last || count_q == CNT_W'(MAX_INFLUENCES - 1)) begin
          count_d = '0;
          state_d = ST_NINIT;
        end else begin
          count_d = count_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_NINIT: begin
        cmd_o.op = OP_NORM_INIT;
        state_d  = ST_NSCALE;
      end
      ST_NSCALE: begin
        if (status_i.top_zero) begin
          state_d = ST_EMIT;
        end else if (status_i.top_big) begin
          cmd_o.op = OP_NSHR;
        end else if (status_i.top_small) begin
          cmd_o.op = OP_NSHL;
        end else begin
          comp_d  = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = ST_SQACC;
      end
      ST_SQACC: begin
        cmd_o.op = OP_SQACC;
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          state_d = ST_SQRT_INIT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_SQ;
        end
      end
      ST_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (status_i.sqrt_last) begin
          state_d = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd_o.op = OP_DIV_INIT;
        step_d   = DIV_TOP;
        state_d  = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == '0) begin
          state_d = ST_DEND;
        end else begin
          step_d = step_q - 4'd1;
        end
      end
      ST_DEND: begin
        cmd_o.op = OP_DIV_END;
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          state_d = ST_EMIT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_DINIT;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/linear_blend_vertex_skinning.sv
// Linear blend skinning of vertices with up to four joint influences each.
// A matrix write request is stored as it is accepted. An applied influence needs,
// for each of the three matrix rows, four word reads and ten passes through the
// one shared 33x33 multiplier. A skipped influence goes straight from acceptance
// to the influence count. Unless the summed normal is zero, the final influence
// of a vertex adds the normalisation: one-bit scaling steps, three squares, a
// 32-step bit-serial square root and three 15-step dividers, before the result
// is loaded into the output register. The matrix store needs no clearing pass.
module linear_blend_vertex_skinning import lbvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [JC_W-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [5:0]         joint_i,
  input  logic [3:0]         word_index_i,
  input  logic signed [31:0] word_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic [15:0]        weight_i,
  input  logic               last_influence_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o,
  output logic signed [15:0] out_norm_x_o,
  output logic signed [15:0] out_norm_y_o,
  output logic signed [15:0] out_norm_z_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  lbvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  lbvs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (command_i),
    .joint_i          (joint_i),
    .word_index_i     (word_index_i),
    .word_value_i     (word_value_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .norm_x_i         (norm_x_i),
    .norm_y_i         (norm_y_i),
    .norm_z_i         (norm_z_i),
    .weight_i         (weight_i),
    .last_influence_i (last_influence_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_pos_x_o      (out_pos_x_o),
    .out_pos_y_o      (out_pos_y_o),
    .out_pos_z_o      (out_pos_z_o),
    .out_norm_x_o     (out_norm_x_o),
    .out_norm_y_o     (out_norm_y_o),
    .out_norm_z_o     (out_norm_z_o)
  );

`ifndef SYNTH
  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_EMIT |-> !(out_valid_o && !out_ready_i))
    else $error("result loaded over a pending result");

  // requests are only taken while the datapath is free
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cmd.op == OP_NONE || cmd.op == OP_ACCEPT))
    else $error("request taken while datapath busy");

  // normal components stay within unit range
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_norm_x_o <= 16'sd16384 && out_norm_x_o >= -16'sd16384
                     && out_norm_y_o <= 16'sd16384 && out_norm_y_o >= -16'sd16384
                     && out_norm_z_o <= 16'sd16384 && out_norm_z_o >= -16'sd16384))
    else $error("normal component out of range");
`endif

endmodule

// File: test/testbench.sv
// self-checking testbench for the linear blend vertex skinning block
`timescale 1ns / 100ps

module testbench;
  import lbvs_pkg::*;

  localparam bit CMD_WRITE     = 1'b0;
  localparam bit CMD_INFLUENCE = 1'b1;
  localparam int STALL_LIMIT   = 6000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic               command;
    logic [5:0]         joint;
    logic [3:0]         word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] pos[3];
    logic signed [15:0] nrm[3];
    logic [15:0]        weight;
    logic               last;
  } request_t;

  typedef struct {
    logic signed [31:0] pos[3];
    logic signed [15:0] nrm[3];
  } vertex_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [JC_W-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               command_i;
  logic [5:0]         joint_i;
  logic [3:0]         word_index_i;
  logic signed [31:0] word_value_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [15:0] norm_x_i, norm_y_i, norm_z_i;
  logic [15:0]        weight_i;
  logic               last_influence_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic signed [15:0] out_norm_x_o, out_norm_y_o, out_norm_z_o;

  request_t    pending_q[$];
  vertex_t     skinned_q[$];
  logic [31:0] skin_words[MEM_DEPTH];
  longint      pos_sum[3];
  longint      nrm_sum[3];
  int          influences_seen;
  int          joints_live;
  int          errors;
  int          idle_cycles;

  linear_blend_vertex_skinning u_top (.*);

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // append one request to the driver queue
  function automatic void queue_request(request_t rq);
    pending_q.insert(pending_q.size(), rq);
  endfunction

  function automatic longint sat_to(longint x, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // skinning predictor: matrix store, accumulators and vertex emission
  function automatic void skin_request(request_t rq);
    longint            m, ps, ns, inc;
    longint unsigned   mag[3], top, len2, len, q;
    bit                neg[3];
    int unsigned       w;
    vertex_t           vx;
    if (rq.command == CMD_WRITE) begin
      if (rq.word_index < WORDS_PER_JOINT)
        skin_words[rq.joint * WORDS_PER_JOINT + rq.word_index] = rq.word_value;
      return;
    end
    w = rq.weight;
    if (w > ONE_WEIGHT) w = ONE_WEIGHT;
    if (w != 0 && rq.joint < joints_live) begin
      for (int r = 0; r < 3; r++) begin
        ps = longint'($signed(skin_words[rq.joint * WORDS_PER_JOINT + 9 + r]));
        ns = 0;
        for (int c = 0; c < 3; c++) begin
          m   = longint'($signed(skin_words[rq.joint * WORDS_PER_JOINT + c * 3 + r]));
          ps += (m * longint'(rq.pos[c])) >>> 16;
          ns += (m * longint'(rq.nrm[c])) >>> 16;
        end
        inc        = (ps * longint'(w)) >>> 15;
        pos_sum[r] = sat_to(pos_sum[r] + inc, 48);
        inc        = (ns * longint'(w)) >>> 15;
        nrm_sum[r] = sat_to(nrm_sum[r] + inc, 40);
      end
    end
    influences_seen++;
    if (!rq.last && influences_seen < MAX_INFLUENCES) return;
    // normalise the summed normal
    top = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = nrm_sum[i] < 0;
      mag[i] = neg[i] ? longint'(-nrm_sum[i]) : longint'(nrm_sum[i]);
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      vx.nrm[0] = 0;
      vx.nrm[1] = NORM_ONE;
      vx.nrm[2] = 0;
    end else begin
      while (top >= (64'd1 << 30)) begin
        top >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (top < (64'd1 << 29)) begin
        top <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      len2 = 0;
      for (int i = 0; i < 3; i++) len2 += mag[i] * mag[i];
      len = floor_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
        q         = (mag[i] * 16384 + len / 2) / len;
        vx.nrm[i] = neg[i] ? -16'(q) : 16'(q);
      end
    end
    for (int i = 0; i < 3; i++) begin
      vx.pos[i]  = 32'(sat_to(pos_sum[i], 32));
      pos_sum[i] = 0;
      nrm_sum[i] = 0;
    end
    influences_seen = 0;
    skinned_q.insert(skinned_q.size(), vx);
  endfunction

  // request driver: bursts with random gaps
  int burst_left, gap_left;
  request_t cur;

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      command_i        <= 1'b0;
      joint_i          <= '0;
      word_index_i     <= '0;
      word_value_i     <= '0;
      pos_x_i          <= '0;
      pos_y_i          <= '0;
      pos_z_i          <= '0;
      norm_x_i         <= '0;
      norm_y_i         <= '0;
      norm_z_i         <= '0;
      weight_i         <= '0;
      last_influence_i <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        skin_request(cur);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          command_i        <= cur.command;
          joint_i          <= cur.joint;
          word_index_i     <= cur.word_index;
          word_value_i     <= cur.word_value;
          pos_x_i          <= cur.pos[0];
          pos_y_i          <= cur.pos[1];
          pos_z_i          <= cur.pos[2];
          norm_x_i         <= cur.nrm[0];
          norm_y_i         <= cur.nrm[1];
          norm_z_i         <= cur.nrm[2];
          weight_i         <= cur.weight;
          last_influence_i <= cur.last;
          next_valid = 1'b1;
          if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // result monitor with its own stall pattern
  int stall_mode, mode_left;

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (skinned_q.size() == 0) begin
          report_mismatch("unexpected vertex result", 1, 0);
        end else begin
          want = skinned_q.pop_front();
          if (out_pos_x_o !== want.pos[0]) report_mismatch("pos x", out_pos_x_o, want.pos[0]);
          if (out_pos_y_o !== want.pos[1]) report_mismatch("pos y", out_pos_y_o, want.pos[1]);
          if (out_pos_z_o !== want.pos[2]) report_mismatch("pos z", out_pos_z_o, want.pos[2]);
          if (out_norm_x_o !== want.nrm[0]) report_mismatch("norm x", out_norm_x_o, want.nrm[0]);
          if (out_norm_y_o !== want.nrm[1]) report_mismatch("norm y", out_norm_y_o, want.nrm[1]);
          if (out_norm_z_o !== want.nrm[2]) report_mismatch("norm z", out_norm_z_o, want.nrm[2]);
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog timeout");
      $display("** linear_blend_vertex_skinning: FAILED **");
      $finish;
    end
  end

  // stimulus helpers
  function automatic logic signed [31:0] rand_fix();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
  endfunction

  function automatic logic signed [15:0] rand_nrm();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
  endfunction

  function automatic request_t word_write(int j, int wi, logic signed [31:0] v);
    request_t rq;
    rq = '{default: '0};
    rq.command    = CMD_WRITE;
    rq.joint      = 6'(j);
    rq.word_index = 4'(wi);
    rq.word_value = v;
    rq.pos        = '{$urandom, $urandom, $urandom};
    rq.nrm        = '{16'($urandom), 16'($urandom), 16'($urandom)};
    rq.weight     = 16'($urandom);
    rq.last       = 1'($urandom);
    return rq;
  endfunction

  function automatic request_t influence(int j, logic [15:0] w, bit last);
    request_t rq;
    rq.command    = CMD_INFLUENCE;
    rq.joint      = 6'(j);
    rq.word_index = 4'($urandom);
    rq.word_value = $urandom;
    for (int i = 0; i < 3; i++) begin
      rq.pos[i] = rand_fix();
      rq.nrm[i] = rand_nrm();
    end
    rq.weight = w;
    rq.last   = last;
    return rq;
  endfunction

  // one vertex of one to four influences, sometimes malformed
  task automatic push_vertex();
    int n, left, w;
    bit forced;
    n      = $urandom_range(1, MAX_INFLUENCES);
    forced = ($urandom_range(0, 9) == 0);
    left   = 32768;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = $urandom_range(0, 65535);
        default: w = (k == n - 1) ? left : $urandom_range(0, left);
      endcase
      if (w <= left) left -= w;
      queue_request(influence(
        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
          $urandom_range(0, (joints_live > 0) ? joints_live - 1 : 0),
        16'(w), (k == n - 1) && !forced));
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (skinned_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_joint_count(int v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= JC_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    joints_live = v;
  endtask

  // main sequence
  initial begin
    int limits[8] = '{64, 0, 1, 37, 64, 20, 63, 64};
    request_t rq;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    joints_live = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // load every matrix: identity at joint 0, extreme words at joint 63
    for (int j = 0; j < MAX_JOINTS; j++)
      for (int wi = 0; wi < WORDS_PER_JOINT; wi++) begin
        if (j == 0)
          queue_request(word_write(j, wi, (wi % 4 == 0) ? 32'sh10000 : 32'sd0));
        else if (j == MAX_JOINTS - 1)
          queue_request(word_write(j, wi, wi[0] ? 32'sh7fffffff : 32'sh80000000));
        else
          queue_request(word_write(j, wi, rand_fix()));
      end
    wait_idle();
    write_joint_count(MAX_JOINTS);

    // directed corners
    for (int wi = WORDS_PER_JOINT; wi < 16; wi++)
      queue_request(word_write(5, wi, $urandom));
    rq = influence(0, ONE_WEIGHT, 1'b1);
    rq.pos = '{32'sh7fffffff, 32'sh80000000, 32'sd0};
    rq.nrm = '{16'sh7fff, 16'sh8000, 16'sd0};
    queue_request(rq);
    rq = influence(MAX_JOINTS - 1, 16'hffff, 1'b0);
    rq.pos = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    queue_request(rq);
    rq.pos = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    rq.nrm = '{16'sh8000, 16'sh8000, 16'sh8000};
    rq.last = 1'b1;
    queue_request(rq);
    // zero normal gives the up vector
    rq = influence(0, ONE_WEIGHT, 1'b1);
    rq.nrm = '{16'sd0, 16'sd0, 16'sd0};
    queue_request(rq);
    // zero weight only
    queue_request(influence(3, 16'd0, 1'b1));
    // four influences without a last flag end the vertex
    for (int k = 0; k < MAX_INFLUENCES; k++)
      queue_request(influence(k, 16'd8192, 1'b0));
    queue_request(influence(1, 16'd1, 1'b1));
    wait_idle();
    write_joint_count(2);
    // joints at and beyond the live count are skipped
    queue_request(influence(2, ONE_WEIGHT, 1'b0));
    queue_request(influence(63, ONE_WEIGHT, 1'b0));
    queue_request(influence(1, 16'd16384, 1'b1));
    wait_idle();

    // random phases across joint counts
    foreach (limits[p]) begin
      write_joint_count(limits[p]);
      while (pending_q.size() < 50) begin
        if ($urandom_range(0, 9) == 0)
          queue_request(word_write($urandom_range(0, 63), $urandom_range(0, 15),
                                   rand_fix()));
        else
          push_vertex();
      end
      wait_idle();
    end

    if (errors == 0 && skinned_q.size() == 0) begin
      $display("** linear_blend_vertex_skinning: PASSED **");
    end else begin
      $display("** linear_blend_vertex_skinning: FAILED **");
    end
    $finish;
  end

endmodule
